>>> sv/dltp_pkg.sv
`default_nettype none

package dltp_pkg;

	localparam int DEF_MAX_TASKS = 16;
	// index carried through the scan chain; holds any index up to 255
	localparam int IDX_W     = 8;
	localparam int OUT_IDX_W = 4;
	localparam int DL_W      = 16;
	localparam int CMP_W     = 15;
	localparam int TS_W      = 16;
	localparam int KEY_W     = DL_W + 1;

	localparam logic MODE_EDF = 1'b0;
	localparam logic MODE_LLF = 1'b1;

	// best candidate seen so far along the chain
	typedef struct packed {
		logic                    has;
		logic [IDX_W-1:0]        idx;
		logic signed [KEY_W-1:0] key;
		logic [CMP_W-1:0]        comp;
	} cand_t;

	// bundle handed from cell to cell during a scan
	typedef struct packed {
		logic  go;
		cand_t elig;
		cand_t any;
	} scan_t;

	// true when candidate a strictly beats b; equal entries keep b (lower index)
	function automatic logic beats(input logic mode,
			input logic signed [KEY_W-1:0] ka, input logic [CMP_W-1:0] ca,
			input logic signed [KEY_W-1:0] kb, input logic [CMP_W-1:0] cb);
		logic r;
		if (ka != kb) begin
			r = (ka < kb);
		end else if (mode == MODE_LLF) begin
			r = (ca > cb);
		end else begin
			r = (ca < cb);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/dltp_cell.sv
`default_nettype none

module dltp_cell #(
	parameter int CELL_IDX  = 0,
	parameter int CW        = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load_en,
	input  wire logic                         ld_active,
	input  wire logic [dltp_pkg::DL_W-1:0]    ld_deadline,
	input  wire logic [dltp_pkg::CMP_W-1:0]   ld_compute,
	input  wire logic [dltp_pkg::TS_W-1:0]    ld_served,
	input  wire logic [CW-1:0]                count,
	input  wire logic [dltp_pkg::TS_W-1:0]    latest,
	input  wire logic                         mode,
	input  wire dltp_pkg::scan_t              scan_in,
	output      dltp_pkg::scan_t              scan_out
);
	import dltp_pkg::*;

	logic                    act_q;
	logic [DL_W-1:0]         dl_q;
	logic [CMP_W-1:0]        cmp_q;
	logic [TS_W-1:0]         srv_q;
	logic                    go_q;
	cand_t                   elig_q;
	cand_t                   any_q;

	logic signed [KEY_W-1:0] my_key;
	logic                    in_set;
	logic                    mine;
	logic                    elig;
	logic                    take_e;
	logic                    take_a;
	cand_t                   my_cand;

	// task record held by this cell
	always_ff @(posedge clk) begin
		if (load_en) begin
			act_q <= ld_active;
			dl_q  <= ld_deadline;
			cmp_q <= ld_compute;
			srv_q <= ld_served;
		end
	end

	// key and compare against the incoming best
	always_comb begin
		if (mode == MODE_LLF) begin
			my_key = $signed({dl_q[DL_W-1], dl_q}) - $signed({2'b00, cmp_q});
		end else begin
			my_key = $signed({dl_q[DL_W-1], dl_q});
		end
		in_set  = (CW'(CELL_IDX) < count);
		mine    = in_set & act_q;
		elig    = mine & (srv_q != latest);
		my_cand = '{has: 1'b1, idx: IDX_W'(CELL_IDX), key: my_key, comp: cmp_q};
		take_e  = elig & (!scan_in.elig.has |
			beats(mode, my_key, cmp_q, scan_in.elig.key, scan_in.elig.comp));
		take_a  = mine & (!scan_in.any.has |
			beats(mode, my_key, cmp_q, scan_in.any.key, scan_in.any.comp));
	end

	// scan token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else begin
			go_q <= scan_in.go;
		end
	end

	// best-so-far handed to the next cell
	always_ff @(posedge clk) begin
		elig_q <= take_e ? my_cand : scan_in.elig;
		any_q  <= take_a ? my_cand : scan_in.any;
	end

	assign scan_out = '{go: go_q, elig: elig_q, any: any_q};

endmodule

`default_nettype wire

>>> sv/deadline_laxity_task_picker.sv
// Task records load at one per cycle while busy is low; records past capacity are dropped.
// A record with is_last starts a scan through a chain of MAX_TASKS cells, one cell per cycle.
// result_strobe rises once the scan token has passed the go register, every cell and the
// strobe register; busy is high from the cycle after the closing request is taken and falls
// as the strobe rises. The receiver cannot stall; each result shows for one cycle.
// arst_n clears the policy mode, fill count, current time, busy and strobe.
`default_nettype none

module deadline_laxity_task_picker #(
	parameter int MAX_TASKS = dltp_pkg::DEF_MAX_TASKS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic [15:0]                      instr_done,
	input  wire logic [15:0]                      instr_total,
	input  wire logic signed [dltp_pkg::DL_W-1:0] deadline_left,
	input  wire logic [dltp_pkg::CMP_W-1:0]       compute_left,
	input  wire logic [dltp_pkg::TS_W-1:0]        served_time,
	input  wire logic                             is_last,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic                             cfg_data,
	output      logic                             result_strobe,
	output      logic [dltp_pkg::OUT_IDX_W-1:0]   chosen_index,
	output      logic                             found
);
	import dltp_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);

	logic            mode_q;
	logic [CW-1:0]   count_q;
	logic [TS_W-1:0] latest_q;
	logic            busy_q;
	logic            go_q;
	logic            strobe_q;
	logic [OUT_IDX_W-1:0] index_q;
	logic            found_q;

	logic            accept;
	logic            store;
	logic            ld_active;
	scan_t           chain [MAX_TASKS+1];
	scan_t           tail;

	assign accept    = start & ~busy_q;
	assign store     = accept & (count_q < CW'(MAX_TASKS));
	assign ld_active = (instr_done < instr_total);
	assign chain[0]  = '{go: go_q, elig: '0, any: '0};
	assign tail      = chain[MAX_TASKS];

	// row of task cells
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		dltp_cell #(
			.CELL_IDX  (i),
			.CW        (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.load_en     (store && (count_q == CW'(i))),
			.ld_active   (ld_active),
			.ld_deadline (deadline_left),
			.ld_compute  (compute_left),
			.ld_served   (served_time),
			.count       (count_q),
			.latest      (latest_q),
			.mode        (mode_q),
			.scan_in     (chain[i]),
			.scan_out    (chain[i+1])
		);
	end

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EDF;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// fill count, current time and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			latest_q <= '0;
			busy_q   <= 1'b0;
			go_q     <= 1'b0;
			strobe_q <= 1'b0;
			index_q  <= '0;
			found_q  <= 1'b0;
		end else begin
			go_q     <= accept & is_last;
			strobe_q <= tail.go;
			if (store) begin
				count_q <= count_q + CW'(1);
				if (served_time > latest_q) begin
					latest_q <= served_time;
				end
			end
			if (accept && is_last) begin
				busy_q <= 1'b1;
			end
			if (tail.go) begin
				busy_q   <= 1'b0;
				count_q  <= '0;
				latest_q <= '0;
				if (tail.elig.has) begin
					index_q <= tail.elig.idx[OUT_IDX_W-1:0];
					found_q <= 1'b1;
				end else if (tail.any.has) begin
					index_q <= tail.any.idx[OUT_IDX_W-1:0];
					found_q <= 1'b1;
				end else begin
					index_q <= '0;
					found_q <= 1'b0;
				end
			end
		end
	end

	// mode stays fixed while a scan runs
	assign busy          = busy_q;
	assign cfg_ready     = ~busy_q;
	assign result_strobe = strobe_q;
	assign chosen_index  = index_q;
	assign found         = found_q;

endmodule

`default_nettype wire

>>> sv/dltp_chk.sv
`default_nettype none

module dltp_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       is_last,
	input wire logic       result_strobe,
	input wire logic [3:0] chosen_index,
	input wire logic       found
);

	// closing request puts the block in busy
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && is_last |=> busy)
		else $error("busy not raised after closing request");

	// a result only ends a busy scan
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without a preceding scan");

	// one result per set, never two in a row
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back-to-back results");

	// empty selection reports index zero
	a_none_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !found |-> chosen_index == 4'd0)
		else $error("nonzero index with no task found");

endmodule

bind deadline_laxity_task_picker dltp_chk u_dltp_chk (.*);

`default_nettype wire
